/* src/plcp_pkg.sv */
//------------------------------------------------------------------------------
// plcp_pkg
// Shared types and codes for the pin and LED command processor.
//------------------------------------------------------------------------------
`default_nettype none

package plcp_pkg;

   localparam int unsigned NumPins    = 4;
   localparam int unsigned MaxBytes   = 8;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [3:0] {
      OP_READ      = 4'h0,
      OP_LED_SET   = 4'h1,
      OP_LED_CLR   = 4'h2,
      OP_LED_LOAD  = 4'h3,
      OP_MODE_IN   = 4'h4,
      OP_MODE_PU   = 4'h5,
      OP_MODE_AN   = 4'h6,
      OP_MODE_OUT  = 4'h7,
      OP_MODE_PWM  = 4'h8,
      OP_OUT_SET   = 4'h9,
      OP_OUT_CLR   = 4'hA,
      OP_OUT_LOAD  = 4'hB,
      OP_PWM_VALUE = 4'hC,
      OP_ANALOG_RD = 4'hD,
      OP_USER_RD   = 4'hE,
      OP_NOP       = 4'hF
   } plcp_op_type;

   localparam logic [3:0] RD_ANGLE  = 4'h0;
   localparam logic [3:0] RD_LEDS   = 4'h8;
   localparam logic [3:0] RD_LEVELS = 4'h9;

   typedef enum logic [1:0] {
      MODE_INPUT  = 2'd0,
      MODE_PULLUP = 2'd1,
      MODE_ANALOG = 2'd2,
      MODE_OUTPUT = 2'd3
   } plcp_mode_type;

   // one queued command: response bytes plus the state after it
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [3:0]               count;
      logic [3:0]               led;
      logic [7:0]               modes;
      logic [3:0]               drive_en;
      logic [3:0]               drive_lvl;
   } plcp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } plcp_queue_status_type;

endpackage

`default_nettype wire

/* src/plcp_channels.sv */
//------------------------------------------------------------------------------
// plcp_channels
// Valid/ready channel interfaces for requests and responses.
//------------------------------------------------------------------------------
`default_nettype none

interface plcp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command;
   logic [3:0]  pin_levels;
   logic [11:0] angle_raw;
   logic [9:0]  analog_zero;
   logic [9:0]  analog_one;
   logic [9:0]  analog_two;
   logic [9:0]  analog_three;
   logic [31:0] user_word;

   modport source (output valid, command, pin_levels, angle_raw, analog_zero,
                   analog_one, analog_two, analog_three, user_word,
                   input ready);
   modport sink   (input valid, command, pin_levels, angle_raw, analog_zero,
                   analog_one, analog_two, analog_three, user_word,
                   output ready);
endinterface

interface plcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;
   logic [3:0] led_bits;
   logic [7:0] pin_modes;
   logic [3:0] drive_enable;
   logic [3:0] drive_level;

   modport source (output valid, data_byte, byte_valid, last, led_bits,
                   pin_modes, drive_enable, drive_level, input ready);
   modport sink   (input valid, data_byte, byte_valid, last, led_bits,
                   pin_modes, drive_enable, drive_level, output ready);
endinterface

`default_nettype wire

/* src/pin_and_led_command_processor.sv */
//------------------------------------------------------------------------------
// pin_and_led_command_processor
// Command byte in, response bytes out; keeps LED, pin mode and drive state.
//
//   channel   dir  payload                                        handshake
//   req_chan  in   command, pin_levels, angle_raw, analog_*, user  valid/ready
//   rsp_chan  out  data_byte, byte_valid, last, state fields       valid/ready
//
// A command is decoded in its accept cycle and queued (two entries); its
// first response is offered once its registered entry reaches the queue head.
// The back end emits one response per cycle while rsp_chan is ready: max(bytes,1)
// responses per command, at most 8 for an analog read of all four pins.
// Reset is synchronous; it empties the queue and restores the default state.
// Requests keep flowing while responses stall until the queue fills; a full
// queue holds ready low even in a cycle that pops.
//------------------------------------------------------------------------------
`default_nettype none

module pin_and_led_command_processor
   import plcp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   plcp_req_if.sink   req_chan,
   plcp_rsp_if.source rsp_chan
);

   plcp_entry_type        push_entry;
   plcp_entry_type        head;
   plcp_queue_status_type q_status;
   logic                  push;
   logic                  pop;

   plcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_status   (q_status),
      .push_entry (push_entry),
      .push_valid (push)
   );

   plcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   plcp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

/* src/plcp_front.sv */
//------------------------------------------------------------------------------
// plcp_front
// Decodes commands, owns LED/mode/output state, builds response entries.
//------------------------------------------------------------------------------
`default_nettype none

module plcp_front
   import plcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   plcp_req_if.sink                   req,
   input  wire plcp_queue_status_type q_status,
   output plcp_entry_type             push_entry,
   output logic                       push_valid
);

   logic [3:0]                 led_ff, led_in;
   plcp_mode_type [NumPins-1:0] modes_ff, modes_in;
   logic [3:0]                 out_ff, out_in;

   plcp_op_type                op;
   logic [3:0]                 arg;
   logic [MaxBytes-1:0][7:0]   bytes;
   logic [3:0]                 count;
   logic [3:0][9:0]            analog;
   logic [9:0]                 sample;
   logic                       do_mode;
   plcp_mode_type              new_mode;
   logic [3:0]                 levels_byte;
   logic [3:0]                 drive_en;
   logic                       accept;

   assign op     = plcp_op_type'(req.command[7:4]);
   assign arg    = req.command[3:0];
   assign analog = {req.analog_three, req.analog_two, req.analog_one, req.analog_zero};
   assign accept = req.valid && !q_status.full;
   assign req.ready  = !q_status.full;
   assign push_valid = accept;

   always_comb begin
      led_in   = led_ff;
      modes_in = modes_ff;
      out_in   = out_ff;
      bytes    = '0;
      count    = 4'd0;
      do_mode  = 1'b0;
      new_mode = MODE_PULLUP;
      sample   = '0;
      for (int i = 0; i < NumPins; i++) begin
         if (modes_ff[i] == MODE_INPUT || modes_ff[i] == MODE_PULLUP) begin
            levels_byte[i] = req.pin_levels[i];
         end else if (modes_ff[i] == MODE_OUTPUT) begin
            levels_byte[i] = out_ff[i];
         end else begin
            levels_byte[i] = 1'b0;
         end
      end
      case (op)
         OP_READ: begin
            case (arg)
               RD_ANGLE: begin
                  bytes[0] = {4'h0, req.angle_raw[11:8]};
                  bytes[1] = req.angle_raw[7:0];
                  count    = 4'd2;
               end
               RD_LEDS: begin
                  bytes[0] = {4'h0, led_ff};
                  count    = 4'd1;
               end
               RD_LEVELS: begin
                  bytes[0] = {4'h0, levels_byte};
                  count    = 4'd1;
               end
               default: ;
            endcase
         end
         OP_LED_SET:   led_in = led_ff | arg;
         OP_LED_CLR:   led_in = led_ff & ~arg;
         OP_LED_LOAD:  led_in = arg;
         OP_MODE_IN: begin
            do_mode  = 1'b1;
            new_mode = MODE_INPUT;
         end
         OP_MODE_PU, OP_MODE_PWM: begin
            do_mode  = 1'b1;
            new_mode = MODE_PULLUP;
         end
         OP_MODE_AN: begin
            do_mode  = 1'b1;
            new_mode = MODE_ANALOG;
         end
         OP_MODE_OUT: begin
            do_mode  = 1'b1;
            new_mode = MODE_OUTPUT;
         end
         OP_OUT_SET:   out_in = out_ff | arg;
         OP_OUT_CLR:   out_in = out_ff & ~arg;
         OP_OUT_LOAD:  out_in = arg;
         OP_ANALOG_RD: begin
            for (int i = NumPins - 1; i >= 0; i--) begin
               if (arg[i]) begin
                  sample = (modes_ff[i] == MODE_ANALOG) ? analog[i] : 10'd0;
                  bytes[count[2:0]]        = {6'h00, sample[9:8]};
                  bytes[count[2:0] + 3'd1] = sample[7:0];
                  count = count + 4'd2;
               end
            end
         end
         OP_USER_RD: begin
            bytes[0] = req.user_word[31:24];
            bytes[1] = req.user_word[23:16];
            bytes[2] = req.user_word[15:8];
            bytes[3] = req.user_word[7:0];
            count    = 4'd4;
         end
         default: ;
      endcase
      if (do_mode) begin
         for (int i = 0; i < NumPins; i++) begin
            if (arg[i]) begin
               modes_in[i] = new_mode;
               if (new_mode == MODE_OUTPUT) begin
                  out_in[i] = 1'b1;
               end
            end
         end
      end
      for (int i = 0; i < NumPins; i++) begin
         drive_en[i] = (modes_in[i] == MODE_OUTPUT);
      end
   end

   always_comb begin
      push_entry.bytes     = bytes;
      push_entry.count     = count;
      push_entry.led       = led_in;
      push_entry.modes     = modes_in;
      push_entry.drive_en  = drive_en;
      push_entry.drive_lvl = out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff   <= '0;
         modes_ff <= {NumPins{MODE_PULLUP}};
         out_ff   <= '0;
      end else if (accept) begin
         led_ff   <= led_in;
         modes_ff <= modes_in;
         out_ff   <= out_in;
      end
   end

endmodule

`default_nettype wire

/* src/plcp_queue.sv */
//------------------------------------------------------------------------------
// plcp_queue
// Two-entry queue of decoded commands between front and back.
//------------------------------------------------------------------------------
`default_nettype none

module plcp_queue
   import plcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire plcp_entry_type        push_entry,
   input  wire logic                  pop,
   output plcp_entry_type             head,
   output plcp_queue_status_type      status
);

   localparam int unsigned PtrW = $clog2(QueueDepth);

   plcp_entry_type              store_ff [QueueDepth];
   logic [PtrW-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]               fill_ff, fill_in;

   assign status.full  = (fill_ff == (PtrW+1)'(QueueDepth));
   assign status.empty = (fill_ff == '0);
   assign head         = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      fill_in   = fill_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* src/plcp_back.sv */
//------------------------------------------------------------------------------
// plcp_back
// Streams the response bytes of the head entry, one per cycle while rsp is ready.
//------------------------------------------------------------------------------
`default_nettype none

module plcp_back
   import plcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plcp_entry_type        head,
   input  wire plcp_queue_status_type q_status,
   output logic                       pop,
   plcp_rsp_if.source                 rsp
);

   localparam int unsigned IdxW = $clog2(MaxBytes);

   logic [IdxW-1:0] idx_ff, idx_in;
   logic            has_bytes;
   logic            is_last;
   logic            fire;

   assign has_bytes = (head.count != 4'd0);
   assign is_last   = !has_bytes || ({1'b0, idx_ff} == head.count - 4'd1);
   assign fire      = rsp.valid && rsp.ready;
   assign pop       = fire && is_last;

   assign rsp.valid        = !q_status.empty;
   assign rsp.data_byte    = has_bytes ? head.bytes[idx_ff] : 8'h00;
   assign rsp.byte_valid   = has_bytes;
   assign rsp.last         = is_last;
   assign rsp.led_bits     = head.led;
   assign rsp.pin_modes    = head.modes;
   assign rsp.drive_enable = head.drive_en;
   assign rsp.drive_level  = head.drive_lvl;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = is_last ? '0 : idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

/* src/plcp_checker.sv */
//------------------------------------------------------------------------------
// plcp_checker
// Port-level checks on the response channel of the command processor.
//------------------------------------------------------------------------------
`default_nettype none

module plcp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_last,
   input wire logic [3:0] rsp_led_bits,
   input wire logic [7:0] rsp_pin_modes,
   input wire logic [3:0] rsp_drive_enable
);

   logic [3:0] out_pins;

   assign out_pins = {&rsp_pin_modes[7:6], &rsp_pin_modes[5:4],
                      &rsp_pin_modes[3:2], &rsp_pin_modes[1:0]};

   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_no_byte_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_data_byte == 8'h00 && rsp_last))
      else $error("empty response not zero or not last");

   a_drive_matches_modes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_enable == out_pins))
      else $error("drive enable disagrees with pin modes");

   a_state_steady_in_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && $stable(rsp_led_bits) && $stable(rsp_pin_modes)))
      else $error("state changed inside one command's responses");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind pin_and_led_command_processor plcp_checker u_plcp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_data_byte    (rsp_chan.data_byte),
   .rsp_byte_valid   (rsp_chan.byte_valid),
   .rsp_last         (rsp_chan.last),
   .rsp_led_bits     (rsp_chan.led_bits),
   .rsp_pin_modes    (rsp_chan.pin_modes),
   .rsp_drive_enable (rsp_chan.drive_enable)
);

`default_nettype wire
